// ===== hw/rtl/hpmb_pkg.sv =====
package hpmb_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 16;

  localparam int COEF_W  = 32;
  localparam int ACC_W   = 64;
  localparam int CFG_W   = 64;
  localparam int PADDR_W = 6;

  // quotient bits produced by the divider, and width after rounding
  localparam int QBITS = COORD_WIDTH + 1;
  localparam int QW    = COORD_WIDTH + 2;
  localparam int IT_W  = $clog2(COORD_WIDTH + 1);

  // signed width that holds a coordinate and a rectangle edge
  localparam int CMP_W = (COORD_WIDTH > 17) ? COORD_WIDTH + 2 : 19;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

  localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (COORD_WIDTH - 1));

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_H00_H01 = 3'd0,
    CFG_H02_H10 = 3'd1,
    CFG_H11_H12 = 3'd2,
    CFG_H20_H21 = 3'd3,
    CFG_H22     = 3'd4,
    CFG_ORIGIN  = 3'd5,
    CFG_EXTENT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] mapped_x;
    logic signed [COORD_WIDTH-1:0] mapped_y;
    logic                          inside_res;
    logic                          all_inside;
    logic                          set_done;
    logic                          fault;
  } result_t;

endpackage

// ===== hw/rtl/homography_point_map_bounds.sv =====
// channel  | direction | handshake             | payload
// point    | in        | point_valid / stall   | point_t  (x, y, last_point)
// result   | out       | result_valid / stall  | result_t (mapped x/y, flags)
// apb      | in        | psel, penable, pready | 64-bit registers at 8*i
//
// one point at a time: the work is the bit-per-cycle divider run twice plus six
// passes through the shared 32x32 multiplier; a zero divisor or an oversized
// quotient skips the divider iterations and finishes early
// point_stall is high while a point is in work; the finished result sits in the
// output register, so the next point is taken while it waits on result_stall
// rst is synchronous: coefficients return to identity, region to empty
module homography_point_map_bounds
  import hpmb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               point_valid,
  output logic               point_stall,
  input  point_t             point,

  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DSET, S_DCHK, S_DITER, S_DRND, S_DFIN, S_OUT
  } state_t;

  // configuration registers
  logic [CFG_W-1:0]  coef0, coef1, coef2, coef3;
  logic [COEF_W-1:0] coef4;
  logic [31:0]       origin, extent;

  state_t state;
  logic [2:0]                    cnt;
  logic [IT_W-1:0]               icnt;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic                          last;
  logic signed [ACC_W-1:0]       prod;
  logic [ACC_W-1:0]              u, v, w;
  logic                          div_sel;
  logic                          nneg, dneg;
  logic [ACC_W-1:0]              nmag, dmag, rem;
  logic [QBITS-1:0]              nlow, q;
  logic [QW-1:0]                 qr;
  logic signed [COORD_WIDTH-1:0] mx, my;
  logic                          flt;
  logic                          all_inside_so_far;

  logic signed [COEF_W-1:0] mul_a, mul_b;
  logic [2:0]               pidx;
  logic [ACC_W-1:0]         num;
  logic [ACC_W:0]           r2;
  logic                     ge;
  logic [QW-1:0]            qneg;
  logic                     fin_neg;
  logic signed [COORD_WIDTH-1:0] fin_res, chk_res;
  logic                     fin_sat;

  logic signed [CMP_W-1:0] mxe, mye, x0e, y0e, rwe, rhe;
  logic                    in_rect;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef0  <= CFG_W'(COEF_ONE);
      coef1  <= '0;
      coef2  <= CFG_W'(COEF_ONE);
      coef3  <= '0;
      coef4  <= COEF_ONE;
      origin <= '0;
      extent <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_reg_t'(paddr[5:3]))
        CFG_H00_H01: coef0  <= pwdata;
        CFG_H02_H10: coef1  <= pwdata;
        CFG_H11_H12: coef2  <= pwdata;
        CFG_H20_H21: coef3  <= pwdata;
        CFG_H22:     coef4  <= pwdata[COEF_W-1:0];
        CFG_ORIGIN:  origin <= pwdata[31:0];
        CFG_EXTENT:  extent <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[5:3]))
      CFG_H00_H01: prdata = coef0;
      CFG_H02_H10: prdata = coef1;
      CFG_H11_H12: prdata = coef2;
      CFG_H20_H21: prdata = coef3;
      CFG_H22:     prdata = CFG_W'(coef4);
      CFG_ORIGIN:  prdata = CFG_W'(origin);
      CFG_EXTENT:  prdata = CFG_W'(extent);
      default:     prdata = '0;
    endcase
  end

  // ---------------- datapath selection ----------------
  always_comb begin
    case (cnt)
      3'd0:    mul_a = $signed(coef0[31:0]);
      3'd1:    mul_a = $signed(coef0[63:32]);
      3'd2:    mul_a = $signed(coef1[63:32]);
      3'd3:    mul_a = $signed(coef2[31:0]);
      3'd4:    mul_a = $signed(coef3[31:0]);
      3'd5:    mul_a = $signed(coef3[63:32]);
      default: mul_a = '0;
    endcase
    mul_b = cnt[0] ? COEF_W'(py) : COEF_W'(px);
  end

  assign pidx = cnt - 3'd1;
  assign num  = div_sel ? v : u;

  // one restoring step
  assign r2 = {rem, nlow[QBITS-1]};
  assign ge = r2 >= {1'b0, dmag};

  // final sign and saturation of the rounded quotient
  assign qneg    = QW'(0) - qr;
  assign fin_neg = (nneg != dneg) && (qr != '0);
  always_comb begin
    fin_sat = 1'b0;
    if (fin_neg) begin
      if (qr > LIM_NEG) begin
        fin_sat = 1'b1;
        fin_res = COORD_MIN;
      end else begin
        fin_res = qneg[COORD_WIDTH-1:0];
      end
    end else begin
      if (qr > LIM_POS) begin
        fin_sat = 1'b1;
        fin_res = COORD_MAX;
      end else begin
        fin_res = qr[COORD_WIDTH-1:0];
      end
    end
  end

  // result when w is zero (zero if the numerator is zero too, else saturated) or the quotient is plainly too big
  always_comb begin
    if (dmag == '0) begin
      if (nmag == '0)
        chk_res = '0;
      else
        chk_res = nneg ? COORD_MIN : COORD_MAX;
    end else begin
      chk_res = (nneg != dneg) ? COORD_MIN : COORD_MAX;
    end
  end

  // rectangle test, left and top edges inclusive
  assign mxe = CMP_W'(mx);
  assign mye = CMP_W'(my);
  assign x0e = CMP_W'($signed(origin[15:0]));
  assign y0e = CMP_W'($signed(origin[31:16]));
  assign rwe = $signed({{(CMP_W-16){1'b0}}, extent[15:0]});
  assign rhe = $signed({{(CMP_W-16){1'b0}}, extent[31:16]});
  assign in_rect = !flt && (mxe >= x0e) && (mxe < x0e + rwe)
                        && (mye >= y0e) && (mye < y0e + rhe);

  assign point_stall = rst || (state != S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_valid      <= 1'b0;
      all_inside_so_far <= 1'b1;
    end else begin
      // the output state reloads the result register itself
      if (result_valid && !result_stall && (state != S_OUT))
        result_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (point_valid) begin
            px      <= point.point_x;
            py      <= point.point_y;
            last    <= point.last_point;
            u       <= ACC_W'($signed(coef1[31:0]));
            v       <= ACC_W'($signed(coef2[63:32]));
            w       <= ACC_W'($signed(coef4));
            flt     <= 1'b0;
            div_sel <= 1'b0;
            cnt     <= '0;
            state   <= S_MUL;
          end
        end

        // product issued at one count is summed at the next
        S_MUL: begin
          prod <= mul_a * mul_b;
          if (cnt != 3'd0) begin
            case (pidx[2:1])
              2'd0:    u <= u + prod;
              2'd1:    v <= v + prod;
              default: w <= w + prod;
            endcase
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6)
            state <= S_DSET;
        end

        S_DSET: begin
          nneg  <= num[ACC_W-1];
          dneg  <= w[ACC_W-1];
          nmag  <= num[ACC_W-1] ? ACC_W'(0) - num : num;
          dmag  <= w[ACC_W-1] ? ACC_W'(0) - w : w;
          state <= S_DCHK;
        end

        S_DCHK: begin
          if ((dmag == '0) || ((nmag >> QBITS) >= dmag)) begin
            flt <= 1'b1;
            if (div_sel)
              my <= chk_res;
            else
              mx <= chk_res;
            div_sel <= 1'b1;
            state   <= div_sel ? S_OUT : S_DSET;
          end else begin
            rem   <= nmag >> QBITS;
            nlow  <= nmag[QBITS-1:0];
            q     <= '0;
            icnt  <= '0;
            state <= S_DITER;
          end
        end

        S_DITER: begin
          rem  <= ge ? ACC_W'(r2 - {1'b0, dmag}) : r2[ACC_W-1:0];
          q    <= {q[QBITS-2:0], ge};
          nlow <= {nlow[QBITS-2:0], 1'b0};
          icnt <= icnt + 1'b1;
          if (icnt == IT_W'(COORD_WIDTH))
            state <= S_DRND;
        end

        // half away from zero on magnitudes: bump when 2r >= d
        S_DRND: begin
          qr    <= {1'b0, q} + QW'({rem, 1'b0} >= {1'b0, dmag});
          state <= S_DFIN;
        end

        S_DFIN: begin
          if (fin_sat)
            flt <= 1'b1;
          if (div_sel)
            my <= fin_res;
          else
            mx <= fin_res;
          div_sel <= 1'b1;
          state   <= div_sel ? S_OUT : S_DSET;
        end

        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid        <= 1'b1;
            result.mapped_x     <= mx;
            result.mapped_y     <= my;
            result.inside_res   <= in_rect;
            result.all_inside   <= all_inside_so_far && in_rect;
            result.set_done     <= last;
            result.fault        <= flt;
            all_inside_so_far   <= last ? 1'b1 : (all_inside_so_far && in_rect);
            state               <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/homography_point_map_bounds_test.sv =====
module homography_point_map_bounds_test;
  import hpmb_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               point_valid = 1'b0;
  logic               point_stall;
  point_t             point = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_t            result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0]   pwdata = '0;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  homography_point_map_bounds u_top (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // mirror of the register file and the running set flag
  logic [63:0] cfg_shadow [7];
  logic [31:0] coef_set [9];
  bit          set_all_inside;

  point_t      pending_points [$];
  result_t     expected_maps [$];
  int          points_queued = 0;
  int          points_taken = 0;
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  initial begin
    cfg_shadow[CFG_H00_H01] = {32'h0, COEF_ONE};
    cfg_shadow[CFG_H02_H10] = '0;
    cfg_shadow[CFG_H11_H12] = {32'h0, COEF_ONE};
    cfg_shadow[CFG_H20_H21] = '0;
    cfg_shadow[CFG_H22]     = {32'h0, COEF_ONE};
    cfg_shadow[CFG_ORIGIN]  = '0;
    cfg_shadow[CFG_EXTENT]  = '0;
    set_all_inside = 1'b1;
  end

  // coefficient k in row-major order h00..h22
  function automatic longint coef_at(int k);
    logic [63:0] r;
    r = cfg_shadow[k / 2];
    return longint'($signed((k % 2) ? r[63:32] : r[31:0]));
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] round_quotient(
    input longint num, input longint den, output bit sat);
    logic [63:0] nmag, dmag, q, r, lim;
    bit          neg;
    sat  = 1'b0;
    nmag = (num < 0) ? 64'(-num) : 64'(num);
    dmag = (den < 0) ? 64'(-den) : 64'(den);
    if (dmag == 0) begin
      sat = 1'b1;
      if (nmag == 0) return '0;
      return (num < 0) ? COORD_MIN : COORD_MAX;
    end
    q = nmag / dmag;
    r = nmag % dmag;
    // half away from zero on magnitudes
    if (r >= dmag - r) q = q + 1;
    neg = ((num < 0) != (den < 0)) && (q != 0);
    lim = 64'd1 << (COORD_WIDTH - 1);
    if (neg) begin
      if (q > lim) begin
        sat = 1'b1;
        q = lim;
      end
      q = 64'd0 - q;
      return q[COORD_WIDTH-1:0];
    end
    if (q > lim - 1) begin
      sat = 1'b1;
      q = lim - 1;
    end
    return q[COORD_WIDTH-1:0];
  endfunction

  function automatic result_t predict_mapping(input point_t p);
    longint  px, py, u, v, w, x0, y0, rw, rh;
    bit      sx, sy, flt, in_rect;
    result_t r;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    u = coef_at(0) * px + coef_at(1) * py + coef_at(2);
    v = coef_at(3) * px + coef_at(4) * py + coef_at(5);
    w = coef_at(6) * px + coef_at(7) * py + coef_at(8);
    r.mapped_x = round_quotient(u, w, sx);
    r.mapped_y = round_quotient(v, w, sy);
    flt = sx | sy;
    x0 = longint'($signed(cfg_shadow[CFG_ORIGIN][15:0]));
    y0 = longint'($signed(cfg_shadow[CFG_ORIGIN][31:16]));
    rw = longint'(cfg_shadow[CFG_EXTENT][15:0]);
    rh = longint'(cfg_shadow[CFG_EXTENT][31:16]);
    in_rect = !flt &&
              longint'(r.mapped_x) >= x0 && longint'(r.mapped_x) < x0 + rw &&
              longint'(r.mapped_y) >= y0 && longint'(r.mapped_y) < y0 + rh;
    r.inside_res = in_rect;
    r.all_inside = set_all_inside && in_rect;
    r.set_done   = p.last_point;
    r.fault      = flt;
    set_all_inside = p.last_point ? 1'b1 : r.all_inside;
    return r;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_maps.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result x=%0d y=%0d in=%b all=%b done=%b flt=%b",
                 got.mapped_x, got.mapped_y, got.inside_res, got.all_inside,
                 got.set_done, got.fault);
      return;
    end
    want = expected_maps.pop_front();
    if (got.mapped_x !== want.mapped_x || got.mapped_y !== want.mapped_y ||
        got.inside_res !== want.inside_res || got.all_inside !== want.all_inside ||
        got.set_done !== want.set_done || got.fault !== want.fault) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"mismatch: exp x=%0d y=%0d in=%b all=%b done=%b flt=%b, ",
                  "got x=%0d y=%0d in=%b all=%b done=%b flt=%b"},
                 want.mapped_x, want.mapped_y, want.inside_res, want.all_inside,
                 want.set_done, want.fault, got.mapped_x, got.mapped_y,
                 got.inside_res, got.all_inside, got.set_done, got.fault);
    end
  endtask

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      if (point_valid && !point_stall) begin
        expected_maps.push_back(predict_mapping(point));
        points_taken++;
      end
      if (!point_valid || !point_stall) begin
        if (pending_points.size() > 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
          point       <= pending_points.pop_front();
          point_valid <= 1'b1;
        end else begin
          point_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      result_stall <= (int'($urandom_range(0, 99)) < recv_stall_pct);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 8);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_shadow[idx] = (idx == CFG_H22 || idx == CFG_ORIGIN || idx == CFG_EXTENT) ?
                      {32'h0, data[31:0]} : data;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_coefs();
    write_reg(CFG_H00_H01, {coef_set[1], coef_set[0]});
    write_reg(CFG_H02_H10, {coef_set[3], coef_set[2]});
    write_reg(CFG_H11_H12, {coef_set[5], coef_set[4]});
    write_reg(CFG_H20_H21, {coef_set[7], coef_set[6]});
    write_reg(CFG_H22, {32'h0, coef_set[8]});
  endtask

  task automatic load_region(input logic [31:0] origin, input logic [31:0] extent);
    write_reg(CFG_ORIGIN, {32'h0, origin});
    write_reg(CFG_EXTENT, {32'h0, extent});
    @(negedge clk);
  endtask

  task automatic push_point(input int x, input int y, input bit last);
    point_t p;
    p.point_x    = x[COORD_WIDTH-1:0];
    p.point_y    = y[COORD_WIDTH-1:0];
    p.last_point = last;
    pending_points.push_back(p);
    points_queued++;
  endtask

  // sender holds off until the block has returned every result
  task automatic wait_until_drained();
    while (!(points_taken == points_queued && expected_maps.size() == 0))
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_between(int lo, int hi);
    return 32'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  initial begin
    int          ph, n, kind, rkind, span, last_div, x, y, k;
    logic [31:0] origin, extent;
    logic [31:0] extremes [7];
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                 COEF_ONE, 32'hFFFF_0000};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: identity map, empty rectangle
    push_point(5, -7, 1'b0);
    push_point(32767, -32768, 1'b1);
    wait_until_drained();

    // half scale: exercises rounding of halves and the rectangle edges
    coef_set = '{32'h8000, 32'h0, 32'h0, 32'h0, 32'h8000, 32'h0, 32'h0, 32'h0, COEF_ONE};
    load_coefs();
    load_region(32'h0, {16'd10, 16'd10});
    push_point(0, 0, 1'b0);
    push_point(18, 18, 1'b0);
    push_point(19, 0, 1'b0);
    push_point(-1, -1, 1'b1);
    push_point(3, -3, 1'b0);
    push_point(32767, -32768, 1'b1);
    push_point(1, 1, 1'b1);
    wait_until_drained();

    // zero denominator everywhere
    coef_set = '{COEF_ONE, 32'h0, 32'h0, 32'h0, COEF_ONE, 32'h0, 32'h0, 32'h0, 32'h0};
    load_coefs();
    load_region(32'h8000_8000, 32'hFFFF_FFFF);
    push_point(0, 0, 1'b0);
    push_point(5, -5, 1'b0);
    push_point(-32768, 32767, 1'b1);
    wait_until_drained();

    // extreme coefficients with unit denominator: results overflow
    coef_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h1};
    load_coefs();
    push_point(1, 0, 1'b0);
    push_point(0, 0, 1'b0);
    push_point(-32768, -32768, 1'b0);
    push_point(32767, 32767, 1'b1);
    push_point(0, 1, 1'b1);
    wait_until_drained();

    // negative scale against a rectangle that spans the whole range
    coef_set = '{COEF_ONE, 32'h0, 32'h0, 32'h0, COEF_ONE, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000};
    load_coefs();
    @(negedge clk);
    push_point(-32767, 32767, 1'b0);
    push_point(32767, 32767, 1'b0);
    push_point(-32768, 0, 1'b1);
    wait_until_drained();

    for (ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      kind = $urandom_range(0, 9);
      span = 400;
      // mild projective map near identity by default
      coef_set[0] = rand_between(32768, 98304);
      coef_set[1] = rand_between(-16384, 16384);
      coef_set[2] = rand_between(-6553600, 6553600);
      coef_set[3] = rand_between(-16384, 16384);
      coef_set[4] = rand_between(32768, 98304);
      coef_set[5] = rand_between(-6553600, 6553600);
      coef_set[6] = rand_between(-60, 60);
      coef_set[7] = rand_between(-60, 60);
      coef_set[8] = rand_between(57344, 73728);
      case (kind)
        5: begin
          // denominator crosses zero inside a small window of points
          coef_set[6] = COEF_ONE;
          coef_set[7] = rand_between(-2, 2) * COEF_ONE;
          coef_set[8] = rand_between(-4, 4) * COEF_ONE;
          span = 8;
        end
        6, 7: begin
          for (k = 0; k < 9; k++) coef_set[k] = $urandom();
        end
        8: begin
          for (k = 0; k < 9; k++) coef_set[k] = extremes[$urandom_range(0, 6)];
          span = 40;
        end
        9: begin
          // half steps with an even scale
          for (k = 0; k < 6; k++) coef_set[k] = rand_between(-4, 4) * 32'h8000;
          coef_set[6] = 32'h0;
          coef_set[7] = 32'h0;
          coef_set[8] = rand_between(1, 4) * COEF_ONE;
          if ($urandom_range(0, 1)) coef_set[8] = 32'h0 - coef_set[8];
          span = 100;
        end
        default: ;
      endcase
      load_coefs();
      rkind = $urandom_range(0, 5);
      case (rkind)
        0: begin
          origin = $urandom();
          extent = $urandom();
          if ($urandom_range(0, 1)) extent[15:0] = 16'h0;
          else extent[31:16] = 16'h0;
        end
        1: begin
          origin = 32'h8000_8000;
          extent = 32'hFFFF_FFFF;
        end
        default: begin
          origin[15:0]  = rand_between(-500, 300);
          origin[31:16] = rand_between(-500, 300);
          extent[15:0]  = rand_between(1, 900);
          extent[31:16] = rand_between(1, 900);
        end
      endcase
      load_region(origin, extent);
      last_div = $urandom_range(1, 7);
      for (n = 0; n < 95; n++) begin
        if ($urandom_range(0, 99) < 15) x = int'($urandom_range(0, 65535)) - 32768;
        else x = int'($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(0, 99) < 15) y = int'($urandom_range(0, 65535)) - 32768;
        else y = int'($urandom_range(0, 2 * span)) - span;
        push_point(x, y, $urandom_range(0, last_div) == 0);
      end
      wait_until_drained();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_maps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
